FILE: hw/rtl/bfc_pkg.sv
package bfc_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 65536;
    localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int unsigned CALC_W = ((CNT_W > 18) ? CNT_W : 18) + 1;
    localparam int unsigned TAIL_DEPTH = 6;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam int unsigned ENTRY_W = 16;
    localparam int unsigned DLEN_W = 17;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_COUNT = 3'd2,
        ST_CRC_ERR   = 3'd3,
        ST_LONG      = 3'd4
    } status_t;

    typedef struct packed {
        status_t             status;
        logic [ENTRY_W-1:0]  entry_count;
        logic [DLEN_W-1:0]   data_length;
    } result_t;

    // Reflected CRC-32, one byte, unrolled over its eight bits.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/bfc_frame_state.sv
module bfc_frame_state
    import bfc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    frame_byte,
    input  logic          frame_end,
    input  logic          crc_mode,
    output result_t       result
);

    logic [31:0]      crc_reg;
    logic [31:0]      crc_next;
    logic [7:0]       tail_reg [TAIL_DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             ovf_reg;
    logic             ovf_next;

    logic [CNT_W:0]    size_raw;
    logic              size_over;
    logic [CALC_W-1:0] size_ext;
    logic [15:0]       entry;
    logic [CALC_W-1:0] hdr_len;
    logic [CALC_W-1:0] need;
    logic [CALC_W-1:0] dlen;
    logic [31:0]       saved_crc;

    localparam logic [CNT_W:0] MAX_SIZE = (CNT_W + 1)'(MAX_FRAME_BYTES);

    always_comb
    begin
        crc_next = (count_reg >= CNT_W'(4)) ? crc_byte(crc_reg, tail_reg[3]) : crc_reg;

        size_raw  = {1'b0, count_reg} + (CNT_W + 1)'(1);
        size_over = size_raw > MAX_SIZE;
        ovf_next  = ovf_reg | size_over;
        count_next = size_over ? MAX_SIZE[CNT_W-1:0] : size_raw[CNT_W-1:0];
        size_ext  = CALC_W'(count_next);

        entry     = crc_mode ? {tail_reg[3], tail_reg[4]} : {frame_byte, tail_reg[0]};
        hdr_len   = crc_mode ? CALC_W'(6) : CALC_W'(2);
        need      = hdr_len + CALC_W'({entry, 1'b0});
        dlen      = size_ext - need;
        saved_crc = {frame_byte, tail_reg[0], tail_reg[1], tail_reg[2]};

        result.status      = ST_OK;
        result.entry_count = entry;
        result.data_length = '0;
        if (ovf_next)
        begin
            result.status      = ST_LONG;
            result.entry_count = '0;
        end
        else if (size_ext < hdr_len)
        begin
            result.status      = ST_SHORT;
            result.entry_count = '0;
        end
        else if (size_ext < need)
        begin
            result.status = ST_BAD_COUNT;
        end
        else if (crc_mode && (saved_crc != ~crc_next))
        begin
            result.status = ST_CRC_ERR;
        end
        else
        begin
            result.data_length = dlen[DLEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_INIT;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            for (int i = 0; i < TAIL_DEPTH; i++)
            begin
                tail_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            if (frame_end)
            begin
                crc_reg   <= CRC_INIT;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
                for (int i = 0; i < TAIL_DEPTH; i++)
                begin
                    tail_reg[i] <= '0;
                end
            end
            else
            begin
                crc_reg   <= crc_next;
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
                tail_reg[0] <= frame_byte;
                for (int i = 1; i < TAIL_DEPTH; i++)
                begin
                    tail_reg[i] <= tail_reg[i-1];
                end
            end
        end
    end

endmodule

FILE: hw/rtl/block_frame_checker.sv
// Checks one encoded storage block per frame of byte transfers.
// The slave side takes one block byte per transfer in tdata, with tlast on
// the final byte. A block is a data area, little-endian 16-bit offsets, a
// little-endian 16-bit entry count and, when crc_mode is set, a trailing
// reflected CRC-32 over every byte except the last four.
// Only the final byte of a block yields a master-side transfer: tuser holds
// the status, tdata holds the entry count and the data-area length.
// The cfg channel writes crc_mode, which is sampled on each final byte.
// One byte is accepted every cycle unless a final byte stalls. A byte goes
// through an input register, combinational CRC and length logic and a
// result register.
// The next block's bytes keep flowing while a result waits; only a final
// byte stalls in the input register until the result register frees up.
// Reset clears the frame state, empties both registers and sets crc_mode.
module block_frame_checker
    import bfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // frame_byte
    input  logic        s_axis_tlast,   // frame_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // entry_count[15:0], data_length[32:16], zero
    output logic [2:0]  m_axis_tuser,   // status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data        // crc_mode
);

    logic       crc_mode_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       advance;
    result_t    result;
    logic       out_valid_reg;
    result_t    out_reg;

    assign cfg_ready = 1'b1;
    assign advance = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_mode_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            crc_mode_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    bfc_frame_state u_frame_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .frame_byte (in_byte_reg),
        .frame_end  (in_last_reg),
        .crc_mode   (crc_mode_reg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {7'd0, out_reg.data_length, out_reg.entry_count};

`ifndef SYNTHESIS
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && in_last_reg))
        else $error("Result appeared without a final byte.");

    a_held_byte_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)
            && $stable(in_last_reg)))
        else $error("Stalled byte was lost or changed.");

    a_error_no_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status != ST_OK)) |-> (out_reg.data_length == '0))
        else $error("Failed block reports a data length.");

    a_size_error_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ((out_reg.status == ST_LONG) || (out_reg.status == ST_SHORT)))
            |-> (out_reg.entry_count == '0))
        else $error("Size error reports an entry count.");
`endif

endmodule

FILE: bench/frame_status_checker.sv
`timescale 1ns / 100ps

package bfc_tb_pkg;
    import bfc_pkg::*;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } fill_t;

    // Bit-serial form of the reflected CRC-32 update, data bit first.
    function automatic logic [31:0] crc32_update(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] r;
        r = acc;
        for (int i = 0; i < 8; i++)
        begin
            if (r[0] ^ b[i])
                r = (r >> 1) ^ CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

endpackage

module frame_status_checker
    import bfc_pkg::*;
    import bfc_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // frame_byte
    input  logic        s_axis_tlast,   // frame_end
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // entry_count[15:0], data_length[32:16], zero
    input  logic [2:0]  m_axis_tuser,   // status
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,       // crc_mode
    output int          errors,
    output int          waiting
);

    logic        crc_mode;
    logic [31:0] crc_acc;
    logic [7:0]  tail [TAIL_DEPTH];
    int          seen;
    logic        overflowed;
    result_t     pending_results [$];
    result_t     want;

    task automatic report_mismatch(input string what);
        $display("[%0t] frame check mismatch: %s", $realtime, what);
        errors++;
    endtask

    task automatic clear_frame_state();
        crc_acc = CRC_INIT;
        for (int i = 0; i < TAIL_DEPTH; i++)
        begin
            tail[i] = 8'd0;
        end
        seen = 0;
        overflowed = 1'b0;
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic last);
        int          size;
        int          dlen;
        int          cnt_i;
        int          min_len;
        logic [15:0] count;
        logic [31:0] stored;
        result_t     res;
        if (seen >= 4)
            crc_acc = crc32_update(crc_acc, tail[3]);
        size = seen + 1;
        if (size > MAX_FRAME_BYTES)
        begin
            overflowed = 1'b1;
            size = MAX_FRAME_BYTES;
        end
        if (!last)
        begin
            for (int i = TAIL_DEPTH - 1; i > 0; i--)
            begin
                tail[i] = tail[i - 1];
            end
            tail[0] = b;
            seen = size;
        end
        else
        begin
            res.status = ST_OK;
            count = 16'd0;
            stored = 32'd0;
            dlen = 0;
            min_len = crc_mode ? 6 : 2;
            if (overflowed)
                res.status = ST_LONG;
            else if (size < min_len)
                res.status = ST_SHORT;
            else
            begin
                if (crc_mode)
                begin
                    count = {tail[3], tail[4]};
                    stored = {b, tail[0], tail[1], tail[2]};
                end
                else
                    count = {b, tail[0]};
                cnt_i = count;
                dlen = size - min_len - 2 * cnt_i;
                if (dlen < 0)
                    res.status = ST_BAD_COUNT;
                else if (crc_mode && stored != (crc_acc ^ CRC_INIT))
                    res.status = ST_CRC_ERR;
            end
            res.entry_count = count;
            res.data_length = (res.status == ST_OK) ? dlen[DLEN_W-1:0] : '0;
            pending_results.push_back(res);
            clear_frame_state();
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            errors = 0;
            crc_mode = 1'b1;
            clear_frame_state();
            pending_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                crc_mode = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                predict_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result transfer with no block outstanding");
                else
                begin
                    want = pending_results.pop_front();
                    if (m_axis_tuser !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_axis_tuser, want.status));
                    if (m_axis_tdata[15:0] !== want.entry_count)
                        report_mismatch($sformatf("entry_count %0d, expected %0d",
                                                  m_axis_tdata[15:0], want.entry_count));
                    if (m_axis_tdata[32:16] !== want.data_length)
                        report_mismatch($sformatf("data_length %0d, expected %0d",
                                                  m_axis_tdata[32:16], want.data_length));
                    if (m_axis_tdata[39:33] !== 7'd0)
                        report_mismatch($sformatf("padding bits %b not zero",
                                                  m_axis_tdata[39:33]));
                end
            end
        end
        waiting <= pending_results.size();
    end

endmodule

FILE: bench/tb_block_frame_checker.sv
`timescale 1ns / 100ps

module tb_block_frame_checker;
    import bfc_pkg::*;
    import bfc_tb_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PHASE_BYTES = 260;
    localparam int IDLE_PCT = 12;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;

    int          errors;
    int          waiting;
    int          cycles = 0;
    int          sent = 0;
    logic        calm = 1'b0;
    fill_t       fill_style = FILL_RANDOM;
    logic [7:0]  block_bytes [$];

    block_frame_checker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    frame_status_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .waiting       (waiting)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[block_frame_checker] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic logic [7:0] fill_byte();
        case (fill_style)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic build_block(input logic crc_on, input int data_n, input int offsets_n,
                               input logic [15:0] count_val, input logic [31:0] crc_flip);
        logic [31:0] acc;
        block_bytes.delete();
        repeat (data_n + 2 * offsets_n)
            block_bytes.push_back(fill_byte());
        block_bytes.push_back(count_val[7:0]);
        block_bytes.push_back(count_val[15:8]);
        if (crc_on)
        begin
            acc = CRC_INIT;
            foreach (block_bytes[i])
                acc = crc32_update(acc, block_bytes[i]);
            acc = acc ^ CRC_INIT ^ crc_flip;
            block_bytes.push_back(acc[7:0]);
            block_bytes.push_back(acc[15:8]);
            block_bytes.push_back(acc[23:16]);
            block_bytes.push_back(acc[31:24]);
        end
    endtask

    task automatic build_noise(input int n);
        block_bytes.delete();
        repeat (n)
            block_bytes.push_back(fill_byte());
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_block();
        foreach (block_bytes[i])
            send_byte(block_bytes[i], i == block_bytes.size() - 1);
    endtask

    task automatic set_mode(input logic m);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_block(input logic m);
        int pick;
        int fill_pick;
        int data_n;
        int offs_n;
        int claim;
        pick = $urandom_range(99);
        fill_pick = $urandom_range(19);
        fill_style = (fill_pick == 0) ? FILL_ZERO : (fill_pick == 1) ? FILL_ONES : FILL_RANDOM;
        data_n = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(24);
        offs_n = $urandom_range(6);
        if (pick < 55)
            build_block(m, data_n, offs_n, 16'(offs_n), 32'd0);
        else if (pick < 65)
        begin
            claim = offs_n + data_n / 2 + 1 + $urandom_range(3);
            if ($urandom_range(9) == 0)
                claim = 16'hFFFF;
            build_block(m, data_n, offs_n, 16'(claim), 32'd0);
        end
        else if (pick < 75)
            build_block(m, data_n, offs_n, 16'(offs_n), 32'd1 << $urandom_range(31));
        else if (pick < 85)
            build_noise($urandom_range(1, m ? 5 : 1));
        else if (pick < 95)
            build_noise($urandom_range(1, 30));
        else
            build_block(!m, data_n, offs_n, 16'(offs_n), 32'd0);
        send_block();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // CRC mode is on after reset.
        fill_style = FILL_ONES;
        build_noise(1);
        send_block();
        fill_style = FILL_ZERO;
        build_noise(5);
        send_block();
        build_block(1'b1, 0, 0, 16'd0, 32'd0);
        send_block();
        fill_style = FILL_RANDOM;
        build_block(1'b1, 3, 2, 16'd2, 32'd0);
        send_block();
        build_block(1'b1, 4, 0, 16'hFFFF, 32'd0);
        send_block();
        build_block(1'b1, 5, 1, 16'd1, 32'h8000_0000);
        send_block();
        fill_style = FILL_ONES;
        build_block(1'b1, 7, 0, 16'd0, 32'd0);
        send_block();

        set_mode(1'b0);
        fill_style = FILL_RANDOM;
        build_noise(1);
        send_block();
        fill_style = FILL_ZERO;
        build_noise(2);
        send_block();
        build_block(1'b0, 0, 0, 16'd1, 32'd0);
        send_block();
        fill_style = FILL_RANDOM;
        build_block(1'b0, 6, 2, 16'd2, 32'd0);
        send_block();
        fill_style = FILL_ONES;
        build_noise(3);
        send_block();

        for (int p = 0; p < 4; p++)
        begin
            set_mode(p[0]);
            calm <= (p == 2);
            sent = 0;
            while (sent < PHASE_BYTES)
                random_block(p[0]);
        end
        calm <= 1'b0;

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("[block_frame_checker] OK");
        else
            $display("[block_frame_checker] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/bfc_pkg.sv
hw/rtl/bfc_frame_state.sv
hw/rtl/block_frame_checker.sv
bench/frame_status_checker.sv
bench/tb_block_frame_checker.sv
